// ===== rtl/core/dpb_pkg.sv =====
// Shared types and constants for the depth pixel back-projection block.
// Used by the depth table, the row projection unit, the top level and the checker.
// No dependencies.
`default_nettype none

package dpb_pkg;

  // Field widths of the input and result items.
  localparam int unsigned COORD_W = 12;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned DEPTH_W = 24;
  localparam int unsigned POINT_W = 32;

  // Depth table: depth(n) = DEPTH_NUM / (DEPTH_SLOPE * n + DEPTH_BASE), in Q8.16.
  localparam int unsigned     LUT_DEPTH   = 256;
  localparam longint unsigned DEPTH_NUM   = 64'd1346400;
  localparam longint unsigned DEPTH_BASE  = 64'd11220;
  localparam longint unsigned DEPTH_SLOPE = 64'd76;
  localparam int unsigned     DEPTH_FRAC  = 16;

  // Bounds of the table output, used by the checker.
  localparam logic [DEPTH_W-1:0] DEPTH_MIN = 24'd2883584;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 24'd7864320;

  // Internal datapath widths of one matrix row.
  localparam int unsigned PROD_W = COEF_W + COORD_W + 1;   // coefficient times coordinate
  localparam int unsigned SUM_W  = PROD_W + 2;              // two products plus offset
  localparam int unsigned CLMP_W = 36;                      // holds +-2^34
  localparam int unsigned MUL_W  = CLMP_W + DEPTH_W + 1;    // clamped sum times depth
  localparam int unsigned SHIFT  = 24;                      // Q.40 down to Q.16
  localparam int unsigned RND_W  = MUL_W - SHIFT;

  localparam longint SUM_LIMIT  = 64'sd17179869184;         // 2^34
  localparam longint ROUND_HALF = 64'sd8388608;             // 2^23
  localparam longint POINT_MAX  = 64'sd2147483647;
  localparam longint POINT_MIN  = -64'sd2147483648;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_R0C0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_R0C1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R0C2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R1C0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R1C1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_R1C2 = 3'd5;

  // Reset values of the coefficients (Q8.24).
  localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sd16777216;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sd0;

  // One row of the inverse camera matrix.
  typedef struct packed {
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
  } dpb_row_t;

endpackage

`default_nettype wire

// ===== rtl/core/dpb_depth_lut.sv =====
// Constant table from 8-bit inverse-depth code to true depth in unsigned Q8.16.
// Depends on dpb_pkg for the table constants.
`default_nettype none

module dpb_depth_lut (
  input  wire logic [dpb_pkg::CODE_W-1:0]  code_i,
  output logic      [dpb_pkg::DEPTH_W-1:0] depth_o
);
  import dpb_pkg::*;

  logic [DEPTH_W-1:0] lut [LUT_DEPTH];

  // Each entry is worked out at elaboration, rounded to nearest with ties upward.
  for (genvar g = 0; g < LUT_DEPTH; g++) begin : g_entry
    localparam longint unsigned DEN = DEPTH_SLOPE * longint'(g) + DEPTH_BASE;
    localparam longint unsigned VAL = ((DEPTH_NUM << DEPTH_FRAC) + DEN / 2) / DEN;
    assign lut[g] = VAL[DEPTH_W-1:0];
  end

  assign depth_o = lut[code_i];

endmodule

`default_nettype wire

// ===== rtl/core/dpb_row_unit.sv =====
// Four-stage projection of one matrix row: products, sum and clamp, depth multiply,
// rounding and saturation. Depends on dpb_pkg.
`default_nettype none

module dpb_row_unit (
  input  wire logic                          clk,
  input  wire logic                          en_i,
  input  wire logic [dpb_pkg::COORD_W-1:0]   col_i,
  input  wire logic [dpb_pkg::COORD_W-1:0]   row_i,
  input  wire dpb_pkg::dpb_row_t             coef_i,
  input  wire logic [dpb_pkg::DEPTH_W-1:0]   depth_i,   // used by the third stage
  output logic signed [dpb_pkg::POINT_W-1:0] point_o
);
  import dpb_pkg::*;

  logic signed [PROD_W-1:0]  p0_r, p0_nxt, p1_r, p1_nxt;
  logic signed [SUM_W-1:0]   sum;
  logic signed [CLMP_W-1:0]  s_r, s_nxt;
  logic signed [MUL_W-1:0]   m_r, m_nxt, q;
  logic signed [RND_W-1:0]   t;
  logic signed [POINT_W-1:0] res_r, res_nxt;

  // Stage one: coefficient times column and row.
  assign p0_nxt = coef_i.c0 * $signed({1'b0, col_i});
  assign p1_nxt = coef_i.c1 * $signed({1'b0, row_i});

  // Stage two: row sum with the offset, clamped to plus or minus 2^34.
  always_comb begin
    sum = SUM_W'(p0_r) + SUM_W'(p1_r) + SUM_W'(coef_i.c2);
    if (sum > SUM_W'(SUM_LIMIT)) begin
      s_nxt = CLMP_W'(SUM_LIMIT);
    end else if (sum < SUM_W'(-SUM_LIMIT)) begin
      s_nxt = CLMP_W'(-SUM_LIMIT);
    end else begin
      s_nxt = CLMP_W'(sum);
    end
  end

  // Stage three: scale by the depth.
  assign m_nxt = s_r * $signed({1'b0, depth_i});

  // Stage four: round to Q16.16 with ties upward, then saturate to 32 bits.
  always_comb begin
    q = m_r + MUL_W'(ROUND_HALF);
    t = RND_W'(q >>> SHIFT);
    if (t > RND_W'(POINT_MAX)) begin
      res_nxt = POINT_W'(POINT_MAX);
    end else if (t < RND_W'(POINT_MIN)) begin
      res_nxt = POINT_W'(POINT_MIN);
    end else begin
      res_nxt = POINT_W'(t);
    end
  end

  // Payload registers advance together; a stall holds every stage.
  always_ff @(posedge clk) begin
    if (en_i) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      s_r   <= s_nxt;
      m_r   <= m_nxt;
      res_r <= res_nxt;
    end
  end

  assign point_o = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/depth_pixel_backprojection.sv =====
// Top level of the depth pixel back-projection block: configuration registers,
// valid pipeline and two row units. Depends on dpb_pkg, dpb_depth_lut, dpb_row_unit.
`default_nettype none

// One depth pixel item enters per clock while the output is not stalled, and its 3D point
// leaves through the output register, so the sustained rate is one item per cycle. The
// four stages are set by the row arithmetic: products, sum and clamp, the depth
// multiply, then rounding and saturation. All stages advance together whenever the
// output register is empty or being taken, so in_ready follows out_ready combinationally
// and a stall freezes the pipeline without losing or repeating an item. The inverse
// matrix coefficients must only be written while no item is in flight.
module depth_pixel_backprojection (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Configuration write port.
  input  wire logic                               cfg_we,
  input  wire logic [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dpb_pkg::COEF_W-1:0]         cfg_wdata,
  // Input channel.
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [dpb_pkg::COORD_W-1:0]        in_pix_col,
  input  wire logic [dpb_pkg::COORD_W-1:0]        in_pix_row,
  input  wire logic [dpb_pkg::CODE_W-1:0]         in_depth_code,
  // Result channel.
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [dpb_pkg::POINT_W-1:0]      out_point_x,
  output logic signed [dpb_pkg::POINT_W-1:0]      out_point_y,
  output logic        [dpb_pkg::DEPTH_W-1:0]      out_point_z
);
  import dpb_pkg::*;

  dpb_row_t row0_r, row0_nxt, row1_r, row1_nxt;
  logic     adv;
  logic     v1_r, v2_r, v3_r, v4_r;
  logic [DEPTH_W-1:0] depth0, depth1_r, depth2_r, depth3_r, depth4_r;

  // Coefficient writes; indexes beyond the six registers are ignored.
  always_comb begin
    row0_nxt = row0_r;
    row1_nxt = row1_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_R0C0: row0_nxt.c0 = $signed(cfg_wdata);
        REG_R0C1: row0_nxt.c1 = $signed(cfg_wdata);
        REG_R0C2: row0_nxt.c2 = $signed(cfg_wdata);
        REG_R1C0: row1_nxt.c0 = $signed(cfg_wdata);
        REG_R1C1: row1_nxt.c1 = $signed(cfg_wdata);
        REG_R1C2: row1_nxt.c2 = $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= '{c0: COEF_ONE,  c1: COEF_ZERO, c2: COEF_ZERO};
      row1_r <= '{c0: COEF_ZERO, c1: COEF_ONE,  c2: COEF_ZERO};
    end else begin
      row0_r <= row0_nxt;
      row1_r <= row1_nxt;
    end
  end

  // The whole pipeline moves when the output register is free or being taken.
  assign adv      = !v4_r || out_ready;
  assign in_ready = adv;

  // Valid bits travel with their items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Depth lookup and its delay line, which also becomes Z.
  dpb_depth_lut u_lut (
    .code_i  (in_depth_code),
    .depth_o (depth0)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      depth1_r <= depth0;
      depth2_r <= depth1_r;
      depth3_r <= depth2_r;
      depth4_r <= depth3_r;
    end
  end

  // X and Y rows.
  dpb_row_unit u_row_x (
    .clk     (clk),
    .en_i    (adv),
    .col_i   (in_pix_col),
    .row_i   (in_pix_row),
    .coef_i  (row0_r),
    .depth_i (depth2_r),
    .point_o (out_point_x)
  );

  dpb_row_unit u_row_y (
    .clk     (clk),
    .en_i    (adv),
    .col_i   (in_pix_col),
    .row_i   (in_pix_row),
    .coef_i  (row1_r),
    .depth_i (depth2_r),
    .point_o (out_point_y)
  );

  assign out_valid   = v4_r;
  assign out_point_z = depth4_r;

endmodule

`default_nettype wire

// ===== rtl/core/dpb_checker.sv =====
// Port-level checks for depth_pixel_backprojection, bound to the top level below.
// Depends on dpb_pkg for the depth bounds.
`default_nettype none

module dpb_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [dpb_pkg::POINT_W-1:0]   out_point_x,
  input wire logic [dpb_pkg::POINT_W-1:0]   out_point_y,
  input wire logic [dpb_pkg::DEPTH_W-1:0]   out_point_z
);
  import dpb_pkg::*;

  // A stalled result item stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_point_x) && $stable(out_point_y) && $stable(out_point_z))
    else $error("result payload changed while stalled");

  // The input side is open whenever the output register can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input held off with a free output register");

  // Z always lies between the near and far planes.
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_z >= DEPTH_MIN && out_point_z <= DEPTH_MAX)
    else $error("depth outside the near and far planes");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

`default_nettype wire

// ===== tb/sv/depth_pixel_backprojection_test.sv =====
// Self-checking testbench for the depth pixel back-projection block.
// Drives pixel items under several inverse camera matrices and checks each 3D point.
// Depends on dpb_pkg and depth_pixel_backprojection.
`timescale 1ns / 1ps

module depth_pixel_backprojection_test;
  import dpb_pkg::*;

  localparam int IMG_WIDTH     = 640;
  localparam int IMG_HEIGHT    = 480;
  localparam int NUM_COEFS     = 6;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_PIXELS  = 140;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 200000;

  // Writes to these indexes must not touch any coefficient.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Depth table: depth(n) = 255*44*120 / (76*n + 255*44), Q8.16, ties rounded up.
  localparam longint unsigned TABLE_NUM   = 64'd1346400;
  localparam longint unsigned TABLE_BASE  = 64'd11220;
  localparam longint unsigned TABLE_SLOPE = 64'd76;

  localparam longint ROW_SUM_CLAMP = 64'sd17179869184;
  localparam longint Q16_MAX       = 64'sd2147483647;
  localparam longint Q16_MIN       = -64'sd2147483648;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh80000000;

  typedef struct {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CODE_W-1:0]  code;
  } pixel_t;

  typedef struct {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic        [DEPTH_W-1:0] z;
  } point_t;

  logic                      clk           = 1'b0;
  logic                      rst_n         = 1'b0;
  logic                      cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index     = '0;
  logic [COEF_W-1:0]         cfg_wdata     = '0;
  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic [COORD_W-1:0]        in_pix_col    = '0;
  logic [COORD_W-1:0]        in_pix_row    = '0;
  logic [CODE_W-1:0]         in_depth_code = '0;
  logic                      out_valid;
  logic                      out_ready     = 1'b0;
  logic signed [POINT_W-1:0] out_point_x;
  logic signed [POINT_W-1:0] out_point_y;
  logic        [DEPTH_W-1:0] out_point_z;

  // Local copy of the inverse matrix, indexed by register index.
  logic signed [COEF_W-1:0] matrix_coef [NUM_COEFS];

  pixel_t pending_pixels  [$];
  point_t expected_points [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int raster_col     = 0;
  int raster_row     = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int stall_mode     = 0;
  int stall_span     = 0;

  depth_pixel_backprojection DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pix_col   (in_pix_col),
    .in_pix_row   (in_pix_row),
    .in_depth_code(in_depth_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_point_x  (out_point_x),
    .out_point_y  (out_point_y),
    .out_point_z  (out_point_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // True depth for an inverse-depth code.
  function automatic logic [DEPTH_W-1:0] depth_for_code(input logic [CODE_W-1:0] code);
    longint unsigned den;
    longint unsigned num;
    den = TABLE_SLOPE * longint'(code) + TABLE_BASE;
    num = TABLE_NUM << 16;
    return DEPTH_W'((num + den / 2) / den);
  endfunction

  // One matrix row applied to (x, y, 1), scaled by depth, rounded to Q16.16 and saturated.
  function automatic logic signed [POINT_W-1:0] project_axis(
    input logic signed [COEF_W-1:0] c0,
    input logic signed [COEF_W-1:0] c1,
    input logic signed [COEF_W-1:0] c2,
    input pixel_t                   px,
    input logic [DEPTH_W-1:0]       depth
  );
    longint row_sum;
    longint scaled;
    longint rounded;
    row_sum = longint'(c0) * longint'(px.col) + longint'(c1) * longint'(px.row)
            + longint'(c2);
    if (row_sum > ROW_SUM_CLAMP) row_sum = ROW_SUM_CLAMP;
    if (row_sum < -ROW_SUM_CLAMP) row_sum = -ROW_SUM_CLAMP;
    scaled  = row_sum * longint'(depth);
    rounded = (scaled + (64'sd1 <<< 23)) >>> 24;
    if (rounded > Q16_MAX) rounded = Q16_MAX;
    if (rounded < Q16_MIN) rounded = Q16_MIN;
    return rounded[POINT_W-1:0];
  endfunction

  function automatic point_t backproject_pixel(input pixel_t px);
    point_t pt;
    pt.z = depth_for_code(px.code);
    pt.x = project_axis(matrix_coef[REG_R0C0], matrix_coef[REG_R0C1],
                        matrix_coef[REG_R0C2], px, pt.z);
    pt.y = project_axis(matrix_coef[REG_R1C0], matrix_coef[REG_R1C1],
                        matrix_coef[REG_R1C2], px, pt.z);
    return pt;
  endfunction

  // One register write per clock; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx < NUM_COEFS) matrix_coef[idx] = value;
  endtask

  task automatic add_pixel(input int col, input int row, input int code);
    pixel_t px;
    px.col  = COORD_W'(col);
    px.row  = COORD_W'(row);
    px.code = CODE_W'(code);
    pending_pixels.push_back(px);
  endtask

  // Mostly raster runs inside the frame, with full-range and corner pixels mixed in.
  task automatic add_random_pixels(input int count);
    int kind;
    int code;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      code = ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255);
      if (kind < 7) begin
        if ($urandom_range(0, 31) == 0) begin
          raster_col = $urandom_range(0, IMG_WIDTH - 1);
          raster_row = $urandom_range(0, IMG_HEIGHT - 1);
        end
        add_pixel(raster_col, raster_row, code);
        raster_col++;
        if (raster_col == IMG_WIDTH) begin
          raster_col = 0;
          raster_row = (raster_row + 1) % IMG_HEIGHT;
        end
      end else if (kind < 9) begin
        add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), code);
      end else begin
        add_pixel(4095 * $urandom_range(0, 1), 4095 * $urandom_range(0, 1), code);
      end
    end
  endtask

  // Sender: bursts of items separated by random gaps.
  always @(posedge clk) begin : drive_pixels
    pixel_t px;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        px.col  = in_pix_col;
        px.row  = in_pix_row;
        px.code = in_depth_code;
        expected_points.push_back(backproject_pixel(px));
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          px = pending_pixels.pop_front();
          in_valid      <= 1'b1;
          in_pix_col    <= px.col;
          in_pix_row    <= px.row;
          in_depth_code <= px.code;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready pattern switches between modes at random intervals.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_span <= $urandom_range(32, 200);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= cycle_count[2];
      endcase
    end
  end

  // Compare each accepted point with the oldest outstanding prediction.
  always @(posedge clk) begin : check_points
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $error("point with no pixel outstanding: x=%0d y=%0d z=%0d",
               out_point_x, out_point_y, out_point_z);
        mismatch_count++;
      end else begin
        want = expected_points.pop_front();
        if (out_point_x !== want.x) begin
          $error("point_x mismatch: expected %0d, got %0d", want.x, out_point_x);
          mismatch_count++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y mismatch: expected %0d, got %0d", want.y, out_point_y);
          mismatch_count++;
        end
        if (out_point_z !== want.z) begin
          $error("point_z mismatch: expected %0d, got %0d", want.z, out_point_z);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout with %0d points outstanding", expected_points.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic signed [COEF_W-1:0] phase_coef [NUM_COEFS];
    matrix_coef[REG_R0C0] = COEF_ONE;
    matrix_coef[REG_R0C1] = COEF_ZERO;
    matrix_coef[REG_R0C2] = COEF_ZERO;
    matrix_coef[REG_R1C0] = COEF_ZERO;
    matrix_coef[REG_R1C1] = COEF_ONE;
    matrix_coef[REG_R1C2] = COEF_ZERO;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        case (phase)
          // Realistic intrinsics: focal length 525, principal point at the frame center.
          1: begin
            phase_coef[REG_R0C0] = 32'sd31957;
            phase_coef[REG_R0C1] = COEF_ZERO;
            phase_coef[REG_R0C2] = -32'sd10226261;
            phase_coef[REG_R1C0] = COEF_ZERO;
            phase_coef[REG_R1C1] = 32'sd31957;
            phase_coef[REG_R1C2] = -32'sd7669584;
          end
          2: foreach (phase_coef[i]) phase_coef[i] = COEF_MAX;
          3: foreach (phase_coef[i]) phase_coef[i] = COEF_MIN;
          4: foreach (phase_coef[i]) phase_coef[i] = $urandom();
          // Moderate coefficients keep most points away from saturation.
          5: foreach (phase_coef[i]) phase_coef[i] = $urandom_range(0, 2097152) - 1048576;
          default: begin
            phase_coef[REG_R0C0] = COEF_MAX;
            phase_coef[REG_R0C1] = COEF_MIN;
            phase_coef[REG_R0C2] = COEF_ZERO;
            phase_coef[REG_R1C0] = -COEF_ONE;
            phase_coef[REG_R1C1] = COEF_ONE;
            phase_coef[REG_R1C2] = COEF_MIN;
          end
        endcase
        write_reg(REG_R0C0, phase_coef[REG_R0C0]);
        write_reg(REG_R0C1, phase_coef[REG_R0C1]);
        write_reg(REG_R0C2, phase_coef[REG_R0C2]);
        write_reg(REG_R1C0, phase_coef[REG_R1C0]);
        write_reg(REG_R1C1, phase_coef[REG_R1C1]);
        write_reg(REG_R1C2, phase_coef[REG_R1C2]);
        // Unused indexes are written with garbage; the matrix must not change.
        if (phase == 2 || phase == 5) begin
          write_reg(REG_SPARE_LO, $urandom());
          write_reg(REG_SPARE_HI, $urandom());
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        add_random_pixels(PHASE_PIXELS);
      end else begin
        // Field extremes, alternating bit patterns, frame edges and pixels outside it.
        add_pixel(0, 0, 0);
        add_pixel(0, 0, 255);
        add_pixel(4095, 4095, 0);
        add_pixel(4095, 4095, 255);
        add_pixel(4095, 0, 1);
        add_pixel(0, 4095, 254);
        add_pixel(IMG_WIDTH - 1, IMG_HEIGHT - 1, 127);
        add_pixel(IMG_WIDTH, IMG_HEIGHT, 128);
        add_pixel(12'hAAA, 12'h555, 8'hAA);
        add_pixel(12'h555, 12'hAAA, 8'h55);
        add_pixel(IMG_WIDTH / 2, IMG_HEIGHT / 2, 64);
        add_pixel(1, 1, 2);
        add_pixel(2048, 2048, 192);
        add_pixel(12, 7, 0);
        add_pixel(IMG_WIDTH - 1, 0, 255);
      end
      // Let the phase drain before the matrix is touched again.
      while (pending_pixels.size() != 0 || in_valid || expected_points.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
